FILE: hw/rtl/vps_pkg.sv
`default_nettype none
package vps_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY_Y      = 3'd0,
    CFG_DT_SQUARED     = 3'd1,
    CFG_SCREEN_WIDTH   = 3'd2,
    CFG_SCREEN_HEIGHT  = 3'd3,
    CFG_DAMPING        = 3'd4,
    CFG_REST_THRESHOLD = 3'd5
  } vps_cfg_idx_t;

  // Fixed field widths.
  localparam int POS_W  = 32;
  localparam int PIX_W  = 16;
  localparam int DAMP_W = 16;
  localparam int THR_W  = 31;

  // Register reset values.
  localparam logic [POS_W-1:0]  GRAVITY_Y_RST      = 32'd65536000;
  localparam logic [POS_W-1:0]  DT_SQUARED_RST     = 32'd1193;
  localparam logic [PIX_W-1:0]  SCREEN_WIDTH_RST   = 16'd800;
  localparam logic [PIX_W-1:0]  SCREEN_HEIGHT_RST  = 16'd600;
  localparam logic [DAMP_W-1:0] DAMPING_RST        = 16'd19661;
  localparam logic [THR_W-1:0]  REST_THRESHOLD_RST = 31'd3277;

  // How the previous position is rewritten after the wall checks.
  typedef struct packed {
    logic x_damp;  // previous x = clamped x + damped x velocity
    logic y_damp;  // previous y = clamped y + damped y velocity
    logic y_stop;  // previous y = clamped y, the particle rests on the floor
  } vps_wall_flags_t;

endpackage
`default_nettype wire

FILE: hw/rtl/vps_wall.sv
`default_nettype none
module vps_wall #(
  parameter int FRAC_BITS   = 16,
  parameter int RADIUS_BITS = 8
) (
  input  wire logic [vps_pkg::POS_W-1:0] cx,
  input  wire logic [vps_pkg::POS_W-1:0] cy,
  input  wire logic [vps_pkg::POS_W-1:0] px,
  input  wire logic [vps_pkg::POS_W-1:0] py,
  input  wire logic [RADIUS_BITS-1:0]    radius,
  input  wire logic [vps_pkg::PIX_W-1:0] screen_width,
  input  wire logic [vps_pkg::PIX_W-1:0] screen_height,
  input  wire logic [vps_pkg::THR_W-1:0] rest_threshold,
  output logic      [vps_pkg::POS_W-1:0] cx_c,
  output logic      [vps_pkg::POS_W-1:0] cy_c,
  output logic      [vps_pkg::POS_W-1:0] vx,
  output logic      [vps_pkg::POS_W-1:0] vy,
  output vps_pkg::vps_wall_flags_t       flags
);
  import vps_pkg::*;

  // Width of the exact wall arithmetic: pixel values shifted up plus sign and carry.
  localparam int BW = ((RADIUS_BITS > PIX_W) ? RADIUS_BITS : PIX_W) + FRAC_BITS;
  localparam int TW = ((BW > POS_W) ? BW : POS_W) + 2;

  logic signed [TW-1:0] r_t, w_t, h_t;
  logic signed [TW-1:0] cx_t, cy_t, cx1_t, cy1_t;
  logic signed [TW-1:0] floor_diff, ceil_diff, right_diff, left_diff;
  logic signed [TW-1:0] h_m_r, w_m_r;
  logic [POS_W-1:0] cx1, cy1;
  logic floor_hit, ceil_hit, right_hit, left_hit, fast_hit;

  // Velocity from before the step.
  assign vx = cx - px;
  assign vy = cy - py;

  // Radius and walls in fixed point, never wrapped.
  assign r_t = $signed({{(TW-RADIUS_BITS-FRAC_BITS){1'b0}}, radius, {FRAC_BITS{1'b0}}});
  assign w_t = $signed({{(TW-PIX_W-FRAC_BITS){1'b0}}, screen_width, {FRAC_BITS{1'b0}}});
  assign h_t = $signed({{(TW-PIX_W-FRAC_BITS){1'b0}}, screen_height, {FRAC_BITS{1'b0}}});
  assign cx_t = $signed({{(TW-POS_W){cx[POS_W-1]}}, cx});
  assign cy_t = $signed({{(TW-POS_W){cy[POS_W-1]}}, cy});
  assign h_m_r = h_t - r_t;
  assign w_m_r = w_t - r_t;

  // Floor, then ceiling on the updated y.
  assign floor_diff = cy_t + r_t - h_t;
  assign floor_hit  = !floor_diff[TW-1];
  assign cy1        = floor_hit ? h_m_r[POS_W-1:0] : cy;
  assign cy1_t      = $signed({{(TW-POS_W){cy1[POS_W-1]}}, cy1});
  assign ceil_diff  = cy1_t - r_t;
  assign ceil_hit   = ceil_diff[TW-1] || (ceil_diff == '0);
  assign cy_c       = ceil_hit ? r_t[POS_W-1:0] : cy1;

  // Right wall, then left wall on the updated x.
  assign right_diff = cx_t + r_t - w_t;
  assign right_hit  = !right_diff[TW-1];
  assign cx1        = right_hit ? w_m_r[POS_W-1:0] : cx;
  assign cx1_t      = $signed({{(TW-POS_W){cx1[POS_W-1]}}, cx1});
  assign left_diff  = cx1_t - r_t;
  assign left_hit   = left_diff[TW-1] || (left_diff == '0);
  assign cx_c       = left_hit ? r_t[POS_W-1:0] : cx1;

  // A floor hit rebounds only above the rest speed.
  assign fast_hit = $signed({vy[POS_W-1], vy}) > $signed({2'b00, rest_threshold});

  assign flags.x_damp = right_hit || left_hit;
  assign flags.y_damp = ceil_hit || (floor_hit && fast_hit);
  assign flags.y_stop = floor_hit && !fast_hit && !ceil_hit;

endmodule
`default_nettype wire

FILE: hw/rtl/vps_mul.sv
`default_nettype none
module vps_mul (
  input  wire logic [vps_pkg::POS_W-1:0]  vx,
  input  wire logic [vps_pkg::POS_W-1:0]  vy,
  input  wire logic [vps_pkg::POS_W-1:0]  ax,
  input  wire logic [vps_pkg::POS_W-1:0]  ay,
  input  wire logic [vps_pkg::DAMP_W-1:0] damping,
  input  wire logic [vps_pkg::POS_W-1:0]  dt_squared,
  output logic      [vps_pkg::POS_W-1:0]  damp_x,
  output logic      [vps_pkg::POS_W-1:0]  damp_y,
  output logic      [vps_pkg::POS_W-1:0]  acc_x,
  output logic      [vps_pkg::POS_W-1:0]  acc_y
);
  import vps_pkg::*;

  localparam int DP_W = POS_W + DAMP_W + 1;
  localparam int AP_W = 2 * POS_W + 1;

  logic signed [DP_W-1:0] dprod_x, dprod_y;
  logic signed [AP_W-1:0] aprod_x, aprod_y;

  // Rebound velocity: signed velocity times unsigned Q0.16 damping.
  assign dprod_x = $signed(vx) * $signed({1'b0, damping});
  assign dprod_y = $signed(vy) * $signed({1'b0, damping});

  // Position change from acceleration: signed times unsigned Q0.32.
  assign aprod_x = $signed(ax) * $signed({1'b0, dt_squared});
  assign aprod_y = $signed(ay) * $signed({1'b0, dt_squared});

  // Dropping the low bits of a two's complement product rounds toward minus infinity.
  assign damp_x = dprod_x[DAMP_W+POS_W-1:DAMP_W];
  assign damp_y = dprod_y[DAMP_W+POS_W-1:DAMP_W];
  assign acc_x  = aprod_x[2*POS_W-1:POS_W];
  assign acc_y  = aprod_y[2*POS_W-1:POS_W];

endmodule
`default_nettype wire

FILE: hw/rtl/vps_verlet.sv
`default_nettype none
module vps_verlet (
  input  wire logic [vps_pkg::POS_W-1:0] cx_c,
  input  wire logic [vps_pkg::POS_W-1:0] cy_c,
  input  wire logic [vps_pkg::POS_W-1:0] px,
  input  wire logic [vps_pkg::POS_W-1:0] py,
  input  wire vps_pkg::vps_wall_flags_t  flags,
  input  wire logic [vps_pkg::POS_W-1:0] damp_x,
  input  wire logic [vps_pkg::POS_W-1:0] damp_y,
  input  wire logic [vps_pkg::POS_W-1:0] acc_x,
  input  wire logic [vps_pkg::POS_W-1:0] acc_y,
  output logic      [vps_pkg::POS_W-1:0] new_x,
  output logic      [vps_pkg::POS_W-1:0] new_y
);
  import vps_pkg::*;

  logic [POS_W-1:0] px_c, py_c;

  // Previous position after the wall response.
  assign px_c = flags.x_damp ? (cx_c + damp_x) : px;

  always_comb begin
    if (flags.y_damp) begin
      py_c = cy_c + damp_y;
    end else if (flags.y_stop) begin
      py_c = cy_c;
    end else begin
      py_c = py;
    end
  end

  // Position Verlet step, wrapping at 32 bits.
  assign new_x = cx_c + (cx_c - px_c) + acc_x;
  assign new_y = cy_c + (cy_c - py_c) + acc_y;

endmodule
`default_nettype wire

FILE: hw/rtl/verlet_particle_step.sv
`default_nettype none
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   pos, old, accel, size_radius, last_particle
// out      output     out_valid / out_ready new_pos, new_old, last_out
// cfg      input      cfg_we                cfg_addr, cfg_wdata
//
// One particle per cycle is accepted and delivered while out_ready stays high.
// A particle sits in the input register, where the wall checks, products
// and Verlet update settle, and then loads the output register.
// Reset clears both valid bits and loads the register defaults.
// A stall on the output holds the output register; an empty input register still takes an item.
module verlet_particle_step #(
  parameter int FRAC_BITS   = 16,
  parameter int RADIUS_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [vps_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [vps_pkg::POS_W-1:0]     cfg_wdata,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [vps_pkg::POS_W-1:0]     in_pos_x,
  input  wire logic [vps_pkg::POS_W-1:0]     in_pos_y,
  input  wire logic [vps_pkg::POS_W-1:0]     in_old_x,
  input  wire logic [vps_pkg::POS_W-1:0]     in_old_y,
  input  wire logic [vps_pkg::POS_W-1:0]     in_accel_x,
  input  wire logic [vps_pkg::POS_W-1:0]     in_accel_y,
  input  wire logic [RADIUS_BITS-1:0]        in_size_radius,
  input  wire logic                          in_last_particle,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [vps_pkg::POS_W-1:0]     out_new_pos_x,
  output logic      [vps_pkg::POS_W-1:0]     out_new_pos_y,
  output logic      [vps_pkg::POS_W-1:0]     out_new_old_x,
  output logic      [vps_pkg::POS_W-1:0]     out_new_old_y,
  output logic                               out_last_out
);
  import vps_pkg::*;

  // Configuration registers.
  logic [POS_W-1:0]  gravity_y_r, dt_squared_r;
  logic [PIX_W-1:0]  screen_width_r, screen_height_r;
  logic [DAMP_W-1:0] damping_r;
  logic [THR_W-1:0]  rest_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_y_r      <= GRAVITY_Y_RST;
      dt_squared_r     <= DT_SQUARED_RST;
      screen_width_r   <= SCREEN_WIDTH_RST;
      screen_height_r  <= SCREEN_HEIGHT_RST;
      damping_r        <= DAMPING_RST;
      rest_threshold_r <= REST_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_GRAVITY_Y:      gravity_y_r      <= cfg_wdata;
        CFG_DT_SQUARED:     dt_squared_r     <= cfg_wdata;
        CFG_SCREEN_WIDTH:   screen_width_r   <= cfg_wdata[PIX_W-1:0];
        CFG_SCREEN_HEIGHT:  screen_height_r  <= cfg_wdata[PIX_W-1:0];
        CFG_DAMPING:        damping_r        <= cfg_wdata[DAMP_W-1:0];
        CFG_REST_THRESHOLD: rest_threshold_r <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits and flow control. A register loads when empty or when it moves on.
  logic s1_v_r, out_v_r;
  logic rdy1, rdy_out;
  logic in_fire, out_fire;

  assign rdy_out  = !out_v_r || out_ready;
  assign rdy1     = !s1_v_r || rdy_out;
  assign in_ready = rdy1;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_valid;
      end
      if (rdy_out) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Input register.
  logic [POS_W-1:0]       s1_cx_r, s1_cy_r, s1_px_r, s1_py_r, s1_ax_r, s1_ay_r;
  logic [RADIUS_BITS-1:0] s1_rad_r;
  logic                   s1_last_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_cx_r   <= in_pos_x;
      s1_cy_r   <= in_pos_y;
      s1_px_r   <= in_old_x;
      s1_py_r   <= in_old_y;
      s1_ax_r   <= in_accel_x;
      s1_ay_r   <= in_accel_y;
      s1_rad_r  <= in_size_radius;
      s1_last_r <= in_last_particle;
    end
  end

  // Wall checks.
  logic [POS_W-1:0] old_x_nxt, old_y_nxt, wall_vx, wall_vy;
  vps_wall_flags_t  wall_flags;

  vps_wall #(
    .FRAC_BITS  (FRAC_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_wall (
    .cx            (s1_cx_r),
    .cy            (s1_cy_r),
    .px            (s1_px_r),
    .py            (s1_py_r),
    .radius        (s1_rad_r),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .rest_threshold(rest_threshold_r),
    .cx_c          (old_x_nxt),
    .cy_c          (old_y_nxt),
    .vx            (wall_vx),
    .vy            (wall_vy),
    .flags         (wall_flags)
  );

  // Products, in parallel with the wall checks.
  logic [POS_W-1:0] ay_grav, damp_x, damp_y, acc_x, acc_y;

  assign ay_grav = s1_ay_r + gravity_y_r;

  vps_mul u_mul (
    .vx        (wall_vx),
    .vy        (wall_vy),
    .ax        (s1_ax_r),
    .ay        (ay_grav),
    .damping   (damping_r),
    .dt_squared(dt_squared_r),
    .damp_x    (damp_x),
    .damp_y    (damp_y),
    .acc_x     (acc_x),
    .acc_y     (acc_y)
  );

  // Verlet update into the output register.
  logic [POS_W-1:0] new_x_nxt, new_y_nxt;

  vps_verlet u_verlet (
    .cx_c  (old_x_nxt),
    .cy_c  (old_y_nxt),
    .px    (s1_px_r),
    .py    (s1_py_r),
    .flags (wall_flags),
    .damp_x(damp_x),
    .damp_y(damp_y),
    .acc_x (acc_x),
    .acc_y (acc_y),
    .new_x (new_x_nxt),
    .new_y (new_y_nxt)
  );

  logic [POS_W-1:0] out_pos_x_r, out_pos_y_r, out_old_x_r, out_old_y_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_pos_x_r <= new_x_nxt;
      out_pos_y_r <= new_y_nxt;
      out_old_x_r <= old_x_nxt;
      out_old_y_r <= old_y_nxt;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_new_pos_x = out_pos_x_r;
  assign out_new_pos_y = out_pos_y_r;
  assign out_new_old_x = out_old_x_r;
  assign out_new_old_y = out_old_y_r;
  assign out_last_out  = out_last_r;

  // Checks on the pipeline control.
  logic [1:0] occ;
  assign occ = {s1_v_r, out_v_r};

  // Items in flight change only by transfers on the two channels.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones(occ) == $countones($past(occ)) + $past(in_fire) - $past(out_fire)))
    else $error("pipeline lost or duplicated an item");

  // An empty pipeline always takes input.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (occ == '0) |-> in_ready)
    else $error("empty pipeline refused input");

  // The floor cannot both stop and rebound a particle.
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !(wall_flags.y_damp && wall_flags.y_stop))
    else $error("conflicting y wall response");

  // With the output taken every cycle, no stage holds back input.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule
`default_nettype wire
